// ===== hdl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants of the timer/serial block
// Opcodes, register selects, accumulator widths, sequencer states and the
// control/status bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package hts_pkg;

  // opcodes of an input word
  localparam logic [2:0] OP_ADVANCE   = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_CLR_OUT   = 3'd3;
  localparam logic [2:0] OP_CLR_IN    = 3'd4;
  localparam logic [2:0] OP_SER_DONE  = 3'd5;

  // register selects
  localparam logic [2:0] REG_DIV = 3'd0;
  localparam logic [2:0] REG_CNT = 3'd1;
  localparam logic [2:0] REG_RLD = 3'd2;
  localparam logic [2:0] REG_TAC = 3'd3;
  localparam logic [2:0] REG_SC  = 3'd4;

  // accumulator widths
  localparam int DACC_W = 16;
  localparam int PRE_W  = 11;
  localparam int SER_W  = 17;
  localparam int SIN_W  = 13;

  // divider step interval and serial timing
  localparam int unsigned DIV_INTERVAL = 256;
  localparam logic [DACC_W-1:0] DIV_STEP = DACC_W'(DIV_INTERVAL);
  localparam logic [SER_W-1:0]  SERIAL_TIMEOUT = SER_W'(50000);
  localparam logic [SIN_W-1:0]  SERIAL_IN_SPAN = SIN_W'(5000);
  localparam logic [7:0]        SC_RX_IDLE     = 8'h80;
  localparam int                TAC_EN_BIT     = 2;
  localparam int                SC_START_BIT   = 7;
  localparam int                SC_CLOCK_BIT   = 0;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_FINISH
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic step;
    logic finish;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic timer_run;
    logic step_ge;
    logic out_free;
  } stat_t;

  // prescaler period selected by timer control bits 1..0
  function automatic logic [PRE_W-1:0] prescale_period(input logic [1:0] sel);
    logic [PRE_W-1:0] p;
    case (sel)
      2'd0:    p = PRE_W'(1024);
      2'd1:    p = PRE_W'(16);
      2'd2:    p = PRE_W'(64);
      default: p = PRE_W'(256);
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/handheld_timer_serial_block.sv =====
// ----------------------------------------------------------------------------
// handheld_timer_serial_block: divider, programmable timer and serial timing
// Each input word yields one result word. A word is taken, runs an execute
// step and a finish step; bus words (read, write, flag clears, serial done)
// and advances with the timer stopped go straight from execute to finish.
// An advance with the timer running adds one counter step per clock while a
// prescaler period is due, then a closing compare, before the finish. The
// loop runs on the single prescale step unit, which does one compare,
// subtract and counter increment per clock. The finish waits while the
// output register still holds an unaccepted result. The next word is taken
// while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module handheld_timer_serial_block (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [2:0] in_reg_select,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_cycles,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_timer_irq,
  output logic       out_serial_irq,
  output logic       out_message_out,
  output logic       out_message_in
);
  import hts_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // latched input word
  logic [2:0] op_r, sel_r;
  logic [7:0] wdat_r, cyc_r;

  // register file
  logic [7:0] div_r, div_nxt, cnt_r, cnt_nxt, rld_r, rld_nxt;
  logic [7:0] tac_r, tac_nxt, sc_r, sc_nxt;

  // accumulators and flags
  logic [DACC_W-1:0] dacc_r, dacc_nxt;
  logic [PRE_W-1:0]  pacc_r, pacc_nxt;
  logic [SER_W-1:0]  sacc_r, sacc_nxt;
  logic [SIN_W-1:0]  iacc_r, iacc_nxt;
  logic              busy_r, busy_nxt, opend_r, opend_nxt, ipend_r, ipend_nxt;

  // per-word results
  logic [7:0] rdat_r, rdat_nxt;
  logic       tirq_r, tirq_nxt, sirq_r, sirq_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] o_rdat_r;
  logic       o_tirq_r, o_sirq_r, o_mout_r, o_min_r;

  // step unit wires
  logic             step_ge, step_wrap;
  logic [PRE_W-1:0] step_acc;
  logic [7:0]       step_cnt;

  // execute-cycle temporaries
  logic [7:0]        sc_mid;
  logic [SER_W-1:0]  ser_sum;
  logic [SIN_W-1:0]  in_sum;
  logic [DACC_W:0]   div_sum;
  logic [DACC_W-1:0] div_sat;

  hts_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  hts_step_unit u_step (
    .accum      (pacc_r),
    .period_sel (tac_r[1:0]),
    .cnt        (cnt_r),
    .rld        (rld_r),
    .ge         (step_ge),
    .accum_nxt  (step_acc),
    .cnt_nxt    (step_cnt),
    .wrap       (step_wrap)
  );

  // status to sequencer
  assign stat.timer_run = (op_r == OP_ADVANCE) && tac_r[TAC_EN_BIT];
  assign stat.step_ge   = step_ge;
  assign stat.out_free  = !out_valid_r || out_ready;

  // capture the input word
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r   <= in_opcode;
      sel_r  <= in_reg_select;
      wdat_r <= in_write_data;
      cyc_r  <= in_cycles;
    end
  end

  // execute and step datapath
  always_comb begin
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    rld_nxt   = rld_r;
    tac_nxt   = tac_r;
    sc_nxt    = sc_r;
    dacc_nxt  = dacc_r;
    pacc_nxt  = pacc_r;
    sacc_nxt  = sacc_r;
    iacc_nxt  = iacc_r;
    busy_nxt  = busy_r;
    opend_nxt = opend_r;
    ipend_nxt = ipend_r;
    rdat_nxt  = rdat_r;
    tirq_nxt  = tirq_r;
    sirq_nxt  = sirq_r;
    sc_mid    = sc_r;
    ser_sum   = sacc_r + SER_W'(cyc_r);
    in_sum    = '0;
    div_sum   = {1'b0, dacc_r} + (DACC_W+1)'(cyc_r);
    div_sat   = div_sum[DACC_W] ? '1 : div_sum[DACC_W-1:0];

    if (ctl.exec) begin
      rdat_nxt = 8'd0;
      tirq_nxt = 1'b0;
      sirq_nxt = 1'b0;
      case (op_r)
        OP_ADVANCE: begin
          // serial transfer start and timeout
          if (!busy_r) begin
            sacc_nxt = '0;
            if (sc_r[SC_START_BIT] && sc_r[SC_CLOCK_BIT]) begin
              busy_nxt  = 1'b1;
              opend_nxt = 1'b1;
            end
          end else begin
            sacc_nxt = ser_sum;
            if (ser_sum > SERIAL_TIMEOUT) begin
              sirq_nxt = 1'b1;
              sc_mid   = {1'b0, sc_r[6:0]};
              busy_nxt = 1'b0;
            end
          end
          sc_nxt = sc_mid;
          // incoming message span
          if (sc_mid == SC_RX_IDLE) begin
            in_sum = iacc_r + SIN_W'(cyc_r);
            if (in_sum > SERIAL_IN_SPAN) begin
              iacc_nxt  = '0;
              ipend_nxt = 1'b1;
            end else begin
              iacc_nxt = in_sum;
            end
          end
          // divider, at most one step
          if (div_sat >= DIV_STEP) begin
            div_nxt  = div_r + 8'd1;
            dacc_nxt = div_sat - DIV_STEP;
          end else begin
            dacc_nxt = div_sat;
          end
          // prescaler accumulate, steps follow in the loop
          if (tac_r[TAC_EN_BIT]) begin
            pacc_nxt = pacc_r + PRE_W'(cyc_r);
          end else begin
            pacc_nxt = '0;
          end
        end
        OP_WRITE: begin
          case (sel_r)
            REG_DIV: div_nxt = wdat_r;
            REG_CNT: cnt_nxt = wdat_r;
            REG_RLD: rld_nxt = wdat_r;
            REG_TAC: tac_nxt = wdat_r;
            REG_SC:  sc_nxt  = wdat_r;
            default: ;
          endcase
        end
        OP_READ: begin
          case (sel_r)
            REG_DIV: rdat_nxt = div_r;
            REG_CNT: rdat_nxt = cnt_r;
            REG_RLD: rdat_nxt = rld_r;
            REG_TAC: rdat_nxt = tac_r;
            REG_SC:  rdat_nxt = sc_r;
            default: rdat_nxt = 8'd0;
          endcase
        end
        OP_CLR_OUT: opend_nxt = 1'b0;
        OP_CLR_IN:  ipend_nxt = 1'b0;
        OP_SER_DONE: begin
          sirq_nxt = 1'b1;
          sc_nxt   = {1'b0, sc_r[6:0]};
          busy_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    // one counter step per cycle
    if (ctl.step) begin
      pacc_nxt = step_acc;
      cnt_nxt  = step_cnt;
      if (step_wrap) tirq_nxt = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= 8'd0;
      cnt_r   <= 8'd0;
      rld_r   <= 8'd0;
      tac_r   <= 8'd0;
      sc_r    <= 8'd0;
      dacc_r  <= '0;
      pacc_r  <= '0;
      sacc_r  <= '0;
      iacc_r  <= '0;
      busy_r  <= 1'b0;
      opend_r <= 1'b0;
      ipend_r <= 1'b0;
    end else begin
      div_r   <= div_nxt;
      cnt_r   <= cnt_nxt;
      rld_r   <= rld_nxt;
      tac_r   <= tac_nxt;
      sc_r    <= sc_nxt;
      dacc_r  <= dacc_nxt;
      pacc_r  <= pacc_nxt;
      sacc_r  <= sacc_nxt;
      iacc_r  <= iacc_nxt;
      busy_r  <= busy_nxt;
      opend_r <= opend_nxt;
      ipend_r <= ipend_nxt;
    end
  end

  // per-word result registers
  always_ff @(posedge clk) begin
    rdat_r <= rdat_nxt;
    tirq_r <= tirq_nxt;
    sirq_r <= sirq_nxt;
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      o_rdat_r <= rdat_r;
      o_tirq_r <= tirq_r;
      o_sirq_r <= sirq_r;
      o_mout_r <= opend_r;
      o_min_r  <= ipend_r && (sc_r == SC_RX_IDLE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = o_rdat_r;
  assign out_timer_irq   = o_tirq_r;
  assign out_serial_irq  = o_sirq_r;
  assign out_message_out = o_mout_r;
  assign out_message_in  = o_min_r;

  // prescale loop leaves less than one period behind
  a_pre_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && stat.timer_run |-> !step_ge)
    else $error("prescale loop ended with a period still due");

  // a busy transfer never holds an expired timeout
  a_ser_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> sacc_r <= SERIAL_TIMEOUT)
    else $error("serial timeout missed while busy");

  // incoming span accumulator stays in range
  a_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iacc_r <= SERIAL_IN_SPAN)
    else $error("incoming span accumulator out of range");

  // a result word appears only from the finish cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.finish))
    else $error("result word without finish");

endmodule

// ===== hdl/hts_step_unit.sv =====
// ----------------------------------------------------------------------------
// hts_step_unit: shared prescaler step unit
// Compares the prescale accumulator against the selected period, subtracts
// one period and increments the counter with reload on wrap.
// ----------------------------------------------------------------------------
module hts_step_unit (
  input  logic [hts_pkg::PRE_W-1:0] accum,
  input  logic [1:0]                period_sel,
  input  logic [7:0]                cnt,
  input  logic [7:0]                rld,
  output logic                      ge,
  output logic [hts_pkg::PRE_W-1:0] accum_nxt,
  output logic [7:0]                cnt_nxt,
  output logic                      wrap
);
  import hts_pkg::*;

  logic [PRE_W-1:0] period;
  logic [7:0]       cnt_inc;

  // compare and subtract one period
  assign period    = prescale_period(period_sel);
  assign ge        = (accum >= period);
  assign accum_nxt = accum - period;

  // counter increment with reload on wrap
  assign cnt_inc = cnt + 8'd1;
  assign wrap    = (cnt_inc == 8'd0);
  assign cnt_nxt = wrap ? rld : cnt_inc;

endmodule

// ===== hdl/hts_seq.sv =====
// ----------------------------------------------------------------------------
// hts_seq: item sequencer
// Accepts a word, runs the execute cycle, loops the step unit while a
// prescaler period is due, then hands the result to the output register.
// ----------------------------------------------------------------------------
module hts_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  hts_pkg::stat_t stat,
  output logic           in_ready,
  output hts_pkg::ctl_t  ctl
);
  import hts_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = stat.timer_run ? ST_STEP : ST_FINISH;
      end
      ST_STEP: begin
        if (!stat.step_ge) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      ST_EXEC:   ctl.exec   = 1'b1;
      ST_STEP:   ctl.step   = stat.step_ge;
      ST_FINISH: ctl.finish = stat.out_free;
      default: ;
    endcase
  end

endmodule
